/* src/set_assoc_cache_lru_lookup_core_macros.svh */
// Assertion macros shared by the cache lookup RTL.
`ifndef SET_ASSOC_CACHE_LRU_LOOKUP_CORE_MACROS_SVH
`define SET_ASSOC_CACHE_LRU_LOOKUP_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SACL_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define SACL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define SACL_ASSERT(label, clk, rst_n, prop, msg)
`define SACL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

/* src/sacl_pkg.sv */
// ----------------------------------------------------------------------------
// sacl_pkg
// Shared types and constants of the set-associative cache lookup core.
// ----------------------------------------------------------------------------
`default_nettype none
package sacl_pkg;
	localparam int SETS_DEF      = 64;
	localparam int WAYS_DEF      = 4;
	localparam int ADDR_BITS_DEF = 32;
	localparam int CNT_W         = 40;
	localparam int CFG_W         = 4;
	localparam int CFG_IDX_W     = 2;

	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BITS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INDEX_BITS  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WAYS_IN_USE = 2'd2;

	localparam logic [1:0] FUNC_WRITE = 2'd1;

	// Controller commands to the datapath.
	typedef struct packed {
		logic capture;
		logic clr_step;
		logic read;
		logic compare;
		logic update;
		logic emit;
	} ctl_cmd_t;

	typedef struct packed {
		logic clr_done;
	} ctl_sts_t;
endpackage
`default_nettype wire

/* src/sacl_ctrl.sv */
// ----------------------------------------------------------------------------
// sacl_ctrl
// Sequencer: clearing pass after reset, then read, compare, update, emit.
// ----------------------------------------------------------------------------
`default_nettype none
module sacl_ctrl (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  start,
	input  sacl_pkg::ctl_sts_t   sts,
	output logic                 busy,
	output sacl_pkg::ctl_cmd_t   cmd
);
	import sacl_pkg::*;

	typedef enum logic [5:0] {
		ST_CLEAR   = 6'b000001,
		ST_IDLE    = 6'b000010,
		ST_READ    = 6'b000100,
		ST_COMPARE = 6'b001000,
		ST_UPDATE  = 6'b010000,
		ST_EMIT    = 6'b100000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_done) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				cmd.read = 1'b1;
				state_d = ST_COMPARE;
			end
			ST_COMPARE: begin
				cmd.compare = 1'b1;
				state_d = ST_UPDATE;
			end
			ST_UPDATE: begin
				cmd.update = 1'b1;
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				cmd.emit = 1'b1;
				state_d = ST_IDLE;
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	assign busy = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_CLEAR;
		else state_q <= state_d;
	end

	`include "set_assoc_cache_lru_lookup_core_macros.svh"
	`SACL_ASSERT(a_onehot, clk, arst_n, $onehot(state_q), "state not one-hot")
	`SACL_ASSERT_NEXT(a_accept, clk, arst_n, start && !busy, state_q == ST_READ,
		"accepted access did not start read")
	`SACL_ASSERT_NEXT(a_emit, clk, arst_n, state_q == ST_UPDATE, state_q == ST_EMIT,
		"update not followed by emit")
endmodule
`default_nettype wire

/* src/sacl_dp.sv */
// ----------------------------------------------------------------------------
// sacl_dp
// Datapath: address split, tag and state memories, LRU update, counters.
// ----------------------------------------------------------------------------
`default_nettype none
module sacl_dp #(
	parameter int SETS      = sacl_pkg::SETS_DEF,
	parameter int WAYS      = sacl_pkg::WAYS_DEF,
	parameter int ADDR_BITS = sacl_pkg::ADDR_BITS_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  sacl_pkg::ctl_cmd_t           cmd,
	output sacl_pkg::ctl_sts_t           sts,
	input  wire                          cfg_we,
	input  wire [sacl_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  wire [sacl_pkg::CFG_W-1:0]    cfg_data,
	input  wire [31:0]                   address,
	input  wire [1:0]                    func,
	output logic                         done,
	output logic                         hit,
	output logic                         writeback,
	output logic [1:0]                   way_used,
	output logic [sacl_pkg::CNT_W-1:0]   access_count,
	output logic [sacl_pkg::CNT_W-1:0]   hit_count,
	output logic [sacl_pkg::CNT_W-1:0]   miss_count,
	output logic [sacl_pkg::CNT_W-1:0]   writeback_count
);
	import sacl_pkg::*;

	localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;
	localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int IDX_LIMIT = $clog2(SETS + 1) - 1;
	localparam int AW = (ADDR_BITS < 32) ? ADDR_BITS : 32;
	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	typedef logic [WAYS-1:0][WAY_W-1:0] order_t;

	// Per-set row memories.
	logic [WAYS-1:0][31:0] tag_mem   [SETS];
	logic [WAYS-1:0]       valid_mem [SETS];
	logic [WAYS-1:0]       dirty_mem [SETS];
	order_t                lru_mem   [SETS];

	logic [3:0] offset_bits_q;
	logic [2:0] index_bits_q;
	logic [2:0] ways_in_use_q;

	logic [SET_W-1:0] clr_ptr_q;
	logic             wr_q;
	logic [SET_W-1:0] set_q;
	logic [31:0]      tag_q;
	logic [WAYS-1:0][31:0] rd_tag_q;
	logic [WAYS-1:0]  rd_valid_q, rd_dirty_q;
	order_t           rd_order_q;
	logic             hit_q, wb_q;
	logic [WAY_W-1:0] way_q;
	logic [CNT_W-1:0] acc_q, hitc_q, missc_q, wbc_q;

	// Address split with clamped configuration.
	logic [2:0]  ib;
	logic [4:0]  nw;
	logic [31:0] addr_m, set_full;
	logic [5:0]  tag_sh;
	always_comb begin
		ib = (32'(index_bits_q) > 32'(IDX_LIMIT)) ? 3'(IDX_LIMIT) : index_bits_q;
		nw = (ways_in_use_q == 3'd0) ? 5'd1 : 5'(ways_in_use_q);
		if (32'(nw) > 32'(WAYS)) nw = 5'(WAYS);
		addr_m = 32'(address[AW-1:0]);
		set_full = (addr_m >> offset_bits_q) & ((32'd1 << ib) - 32'd1);
		tag_sh = 6'(offset_bits_q) + 6'(ib);
	end

	// Compare and victim choice.
	logic             hit_c;
	logic [WAY_W-1:0] hway_c, vway_c, way_c;
	logic             vfound;
	always_comb begin
		hit_c = 1'b0;
		hway_c = '0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (32'(w) < 32'(nw) && rd_valid_q[w] && rd_tag_q[w] == tag_q) begin
				hit_c = 1'b1;
				hway_c = WAY_W'(w);
			end
		end
		vway_c = '0;
		vfound = 1'b0;
		for (int p = 0; p < WAYS; p++) begin
			if (!vfound && 32'(rd_order_q[p]) < 32'(nw)) begin
				vway_c = rd_order_q[p];
				vfound = 1'b1;
			end
		end
		way_c = hit_c ? hway_c : vway_c;
	end

	// Move the used way to the most recent end.
	order_t new_order;
	logic   seen;
	always_comb begin
		seen = 1'b0;
		new_order = rd_order_q;
		for (int p = 0; p < WAYS - 1; p++) begin
			if (rd_order_q[p] == way_q) seen = 1'b1;
			new_order[p] = seen ? rd_order_q[p+1] : rd_order_q[p];
		end
		new_order[WAYS-1] = way_q;
	end

	function automatic order_t reset_order();
		order_t o;
		for (int w = 0; w < WAYS; w++) o[w] = WAY_W'(w);
		return o;
	endfunction

	always_ff @(posedge clk) begin
		if (cmd.clr_step) begin
			valid_mem[clr_ptr_q] <= '0;
			dirty_mem[clr_ptr_q] <= '0;
			lru_mem[clr_ptr_q]   <= reset_order();
		end
		if (cmd.read) begin
			rd_tag_q   <= tag_mem[set_q];
			rd_valid_q <= valid_mem[set_q];
			rd_dirty_q <= dirty_mem[set_q];
			rd_order_q <= lru_mem[set_q];
		end
		if (cmd.update) begin
			lru_mem[set_q] <= new_order;
			if (hit_q) begin
				if (wr_q) dirty_mem[set_q] <= rd_dirty_q | (WAYS'(1) << way_q);
			end else begin
				tag_mem[set_q][way_q] <= tag_q;
				valid_mem[set_q]      <= rd_valid_q | (WAYS'(1) << way_q);
				dirty_mem[set_q]      <= (rd_dirty_q & ~(WAYS'(1) << way_q))
					| (WAYS'(wr_q) << way_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			wr_q   <= (func == FUNC_WRITE);
			set_q  <= (set_full >= 32'(SETS)) ? '0 : SET_W'(set_full);
			tag_q  <= (tag_sh >= 6'd32) ? 32'd0 : (addr_m >> tag_sh);
		end
		if (cmd.compare) begin
			hit_q <= hit_c;
			way_q <= way_c;
			wb_q  <= !hit_c && rd_valid_q[vway_c] && rd_dirty_q[vway_c];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_bits_q <= 4'd6;
			index_bits_q  <= 3'd6;
			ways_in_use_q <= 3'd4;
			clr_ptr_q     <= '0;
			acc_q <= '0; hitc_q <= '0; missc_q <= '0; wbc_q <= '0;
			done <= 1'b0;
		end else begin
			done <= cmd.emit;
			if (cfg_we) begin
				unique case (cfg_idx)
					REG_OFFSET_BITS: offset_bits_q <= cfg_data;
					REG_INDEX_BITS:  index_bits_q  <= cfg_data[2:0];
					REG_WAYS_IN_USE: ways_in_use_q <= cfg_data[2:0];
					default: ;
				endcase
			end
			if (cmd.clr_step) clr_ptr_q <= clr_ptr_q + 1'b1;
			if (cmd.update) begin
				if (acc_q != CNT_MAX) acc_q <= acc_q + 1'b1;
				if (hit_q && hitc_q != CNT_MAX) hitc_q <= hitc_q + 1'b1;
				if (!hit_q && missc_q != CNT_MAX) missc_q <= missc_q + 1'b1;
				if (wb_q && wbc_q != CNT_MAX) wbc_q <= wbc_q + 1'b1;
			end
		end
	end

	assign sts.clr_done = (32'(clr_ptr_q) == 32'(SETS - 1));

	assign hit = hit_q;
	assign writeback = wb_q;
	assign way_used = 2'(way_q);
	assign access_count = acc_q;
	assign hit_count = hitc_q;
	assign miss_count = missc_q;
	assign writeback_count = wbc_q;

	`include "set_assoc_cache_lru_lookup_core_macros.svh"
	`SACL_ASSERT(a_wb_miss, clk, arst_n, !(done && hit_q && wb_q),
		"writeback flagged on a hit")
	`SACL_ASSERT(a_way_range, clk, arst_n, !done || 32'(way_q) < 32'(nw),
		"way out of range")
	`SACL_ASSERT_NEXT(a_count, clk, arst_n, cmd.update && acc_q != CNT_MAX,
		acc_q == $past(acc_q) + 1'b1, "access count did not advance")
endmodule
`default_nettype wire

/* src/set_assoc_cache_lru_lookup_core.sv */
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_lookup_core
// Tag and LRU state lookup of a set-associative write-back cache.
// ----------------------------------------------------------------------------
// Channel   Signals                          Transfer
// access    start, busy, address, func       start high while busy low
// result    done, hit ... writeback_count    done high for one cycle
// config    cfg_we, cfg_idx, cfg_data        cfg_we high
//
// After reset a clearing pass over all SETS sets runs with busy high.
// Each access passes from transfer to done through the read of the set row,
// compare, memory and LRU update, and result strobe; busy drops with done.
// Results cannot be stalled.
// ----------------------------------------------------------------------------
`default_nettype none
module set_assoc_cache_lru_lookup_core #(
	parameter int SETS      = sacl_pkg::SETS_DEF,
	parameter int WAYS      = sacl_pkg::WAYS_DEF,
	parameter int ADDR_BITS = sacl_pkg::ADDR_BITS_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          start,
	output logic                         busy,
	input  wire [31:0]                   address,
	input  wire [1:0]                    func,
	input  wire                          cfg_we,
	input  wire [sacl_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  wire [sacl_pkg::CFG_W-1:0]    cfg_data,
	output logic                         done,
	output logic                         hit,
	output logic                         writeback,
	output logic [1:0]                   way_used,
	output logic [sacl_pkg::CNT_W-1:0]   access_count,
	output logic [sacl_pkg::CNT_W-1:0]   hit_count,
	output logic [sacl_pkg::CNT_W-1:0]   miss_count,
	output logic [sacl_pkg::CNT_W-1:0]   writeback_count
);
	import sacl_pkg::*;

	ctl_cmd_t cmd;
	ctl_sts_t sts;

	sacl_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .sts(sts), .busy(busy), .cmd(cmd)
	);

	sacl_dp #(.SETS(SETS), .WAYS(WAYS), .ADDR_BITS(ADDR_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.address(address), .func(func), .done(done),
		.hit(hit), .writeback(writeback), .way_used(way_used),
		.access_count(access_count), .hit_count(hit_count),
		.miss_count(miss_count), .writeback_count(writeback_count)
	);
endmodule
`default_nettype wire

/* tb/sv/cache_lookup_checker.sv */
// ----------------------------------------------------------------------------
// cache_lookup_checker
// Watches the access, config and result channels of the cache lookup core.
// It keeps its own copy of the tag, dirty and LRU state, predicts each
// result and compares every field of every result strobe.
// ----------------------------------------------------------------------------
`default_nettype none
module cache_lookup_checker (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           start,
	input  wire                           busy,
	input  wire [31:0]                    address,
	input  wire [1:0]                     func,
	input  wire                           cfg_we,
	input  wire [sacl_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  wire [sacl_pkg::CFG_W-1:0]     cfg_data,
	input  wire                           done,
	input  wire                           hit,
	input  wire                           writeback,
	input  wire [1:0]                     way_used,
	input  wire [sacl_pkg::CNT_W-1:0]     access_count,
	input  wire [sacl_pkg::CNT_W-1:0]     hit_count,
	input  wire [sacl_pkg::CNT_W-1:0]     miss_count,
	input  wire [sacl_pkg::CNT_W-1:0]     writeback_count,
	output int                            errors,
	output int                            pending
);
	import sacl_pkg::*;

	localparam int NSETS    = SETS_DEF;
	localparam int NWAYS    = WAYS_DEF;
	localparam int IDX_MAX  = $clog2(NSETS);
	localparam logic [CNT_W-1:0] CNT_TOP = '1;

	typedef struct {
		logic             hit;
		logic             writeback;
		logic [1:0]       way;
		logic [CNT_W-1:0] accesses;
		logic [CNT_W-1:0] hits;
		logic [CNT_W-1:0] misses;
		logic [CNT_W-1:0] writebacks;
	} lookup_result_t;

	lookup_result_t expected_results[$];

	logic [3:0]       offset_cfg;
	logic [2:0]       index_cfg;
	logic [2:0]       ways_cfg;
	logic             valid_q[NSETS][NWAYS];
	logic             dirty_q[NSETS][NWAYS];
	logic [31:0]      tag_q[NSETS][NWAYS];
	int               lru_q[NSETS][NWAYS];
	logic [CNT_W-1:0] accesses_q, hits_q, misses_q, writebacks_q;

	assign pending = expected_results.size();

	function automatic logic [CNT_W-1:0] bump(logic [CNT_W-1:0] v);
		return (v == CNT_TOP) ? v : v + 1'b1;
	endfunction

	// Works out one lookup and updates the shadow cache state.
	function automatic lookup_result_t lookup_access(logic [31:0] addr, logic [1:0] kind);
		lookup_result_t r;
		int ib, nw, set_no, way, pos;
		logic [31:0] tag;
		logic is_write;
		is_write = (kind == FUNC_WRITE);
		ib = (index_cfg > IDX_MAX) ? IDX_MAX : index_cfg;
		nw = (ways_cfg < 1) ? 1 : ((ways_cfg > NWAYS) ? NWAYS : ways_cfg);
		set_no = (addr >> offset_cfg) & ((1 << ib) - 1);
		tag = addr >> (offset_cfg + ib);
		r.hit = 1'b0;
		r.writeback = 1'b0;
		way = 0;
		accesses_q = bump(accesses_q);
		for (int w = 0; w < nw; w++) begin
			if (!r.hit && valid_q[set_no][w] && tag_q[set_no][w] == tag) begin
				r.hit = 1'b1;
				way = w;
			end
		end
		if (r.hit) begin
			hits_q = bump(hits_q);
			if (is_write)
				dirty_q[set_no][way] = 1'b1;
		end else begin
			misses_q = bump(misses_q);
			way = -1;
			for (int p = 0; p < NWAYS; p++)
				if (way < 0 && lru_q[set_no][p] < nw)
					way = lru_q[set_no][p];
			if (valid_q[set_no][way] && dirty_q[set_no][way]) begin
				r.writeback = 1'b1;
				writebacks_q = bump(writebacks_q);
			end
			valid_q[set_no][way] = 1'b1;
			tag_q[set_no][way] = tag;
			dirty_q[set_no][way] = is_write;
		end
		// Move the used way to the most recent end of the order.
		pos = NWAYS - 1;
		for (int p = NWAYS - 1; p >= 0; p--)
			if (lru_q[set_no][p] == way)
				pos = p;
		for (int p = pos; p + 1 < NWAYS; p++)
			lru_q[set_no][p] = lru_q[set_no][p + 1];
		lru_q[set_no][NWAYS - 1] = way;
		r.way = way[1:0];
		r.accesses = accesses_q;
		r.hits = hits_q;
		r.misses = misses_q;
		r.writebacks = writebacks_q;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		lookup_result_t e;
		if (!arst_n) begin
			offset_cfg <= 4'd6;
			index_cfg <= 3'd6;
			ways_cfg <= 3'd4;
			for (int s = 0; s < NSETS; s++)
				for (int w = 0; w < NWAYS; w++) begin
					valid_q[s][w] = 1'b0;
					dirty_q[s][w] = 1'b0;
					tag_q[s][w] = '0;
					lru_q[s][w] = w;
				end
			accesses_q = '0;
			hits_q = '0;
			misses_q = '0;
			writebacks_q = '0;
			expected_results.delete();
			errors = 0;
		end else begin
			// Results are compared before this edge's access is predicted.
			if (done) begin
				if (expected_results.size() == 0) begin
					$error("result transfer with no access outstanding");
					errors++;
				end else begin
					e = expected_results.pop_front();
					if (hit !== e.hit) begin
						$error("hit: expected %0h, got %0h", e.hit, hit);
						errors++;
					end
					if (writeback !== e.writeback) begin
						$error("writeback: expected %0h, got %0h", e.writeback, writeback);
						errors++;
					end
					if (way_used !== e.way) begin
						$error("way_used: expected %0h, got %0h", e.way, way_used);
						errors++;
					end
					if (access_count !== e.accesses) begin
						$error("access_count: expected %0h, got %0h", e.accesses, access_count);
						errors++;
					end
					if (hit_count !== e.hits) begin
						$error("hit_count: expected %0h, got %0h", e.hits, hit_count);
						errors++;
					end
					if (miss_count !== e.misses) begin
						$error("miss_count: expected %0h, got %0h", e.misses, miss_count);
						errors++;
					end
					if (writeback_count !== e.writebacks) begin
						$error("writeback_count: expected %0h, got %0h",
							e.writebacks, writeback_count);
						errors++;
					end
				end
			end
			if (start && !busy)
				expected_results.push_back(lookup_access(address, func));
			if (cfg_we) begin
				case (cfg_idx)
					REG_OFFSET_BITS: offset_cfg <= cfg_data[3:0];
					REG_INDEX_BITS:  index_cfg <= cfg_data[2:0];
					REG_WAYS_IN_USE: ways_cfg <= cfg_data[2:0];
					default: ;
				endcase
			end
		end
	end
endmodule
`default_nettype wire

/* tb/sv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the cache lookup core: directed corner accesses, then random
// accesses over several geometry settings with varying idle gaps. The
// checker beside the core predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_top;
	import sacl_pkg::*;

	localparam int CYCLE_LIMIT = 300000;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	logic [31:0]          address;
	logic [1:0]           func;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_W-1:0]     cfg_data;
	logic                 done;
	logic                 hit;
	logic                 writeback;
	logic [1:0]           way_used;
	logic [CNT_W-1:0]     access_count, hit_count, miss_count, writeback_count;
	int                   errors;
	int                   pending;
	int                   cycles;
	int                   idle_pct;
	logic [31:0]          addr_pool[16];

	set_assoc_cache_lru_lookup_core dut (.*);

	cache_lookup_checker checker_i (.*);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	initial cycles = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Holds start until the access transfers; unless a random idle gap follows,
	// start stays high afterward so a following access can go out back to back.
	task automatic send_access(logic [31:0] a, logic [1:0] f);
		address <= a;
		func <= f;
		start <= 1'b1;
		do
			@(posedge clk);
		while (busy);
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0 || busy)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Leaves the write enable high; the caller drops it after the last write.
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	task automatic set_geometry(logic [3:0] ob, logic [3:0] ib, logic [3:0] nw);
		drain();
		write_reg(REG_OFFSET_BITS, ob);
		write_reg(REG_INDEX_BITS, ib);
		write_reg(REG_WAYS_IN_USE, nw);
		// An index with no register behind it must change nothing.
		write_reg(REG_UNUSED, 4'($urandom));
		cfg_we <= 1'b0;
		foreach (addr_pool[i])
			addr_pool[i] = $urandom;
	endtask

	task automatic random_accesses(int n);
		logic [31:0] a;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(99) < 75)
				a = addr_pool[$urandom_range(15)] ^ ($urandom & 32'hF);
			else
				a = $urandom;
			send_access(a, 2'($urandom_range(3)));
		end
	endtask

	initial begin
		logic [3:0] geo_ob[6] = '{4'd0, 4'd12, 4'd15, 4'd4, 4'd3, 4'd6};
		logic [3:0] geo_ib[6] = '{4'd0, 4'd6, 4'd7, 4'd2, 4'd3, 4'd1};
		logic [3:0] geo_nw[6] = '{4'd1, 4'd4, 4'd0, 4'd7, 4'd2, 4'd3};
		arst_n = 1'b0;
		start = 1'b0;
		address = '0;
		func = '0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_data = '0;
		idle_pct = 11;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		// Directed: all kinds, extreme addresses, hits, and a dirty eviction
		// after five distinct writes fill one set at the reset geometry.
		send_access(32'h0000_0000, 2'd0);
		send_access(32'hFFFF_FFFF, 2'd1);
		send_access(32'h0000_0000, 2'd2);
		send_access(32'hFFFF_FFFF, 2'd3);
		send_access(32'hFFFF_FFC0, 2'd1);
		for (int t = 1; t <= 5; t++)
			send_access(32'(t) << 12, 2'd1);
		send_access(32'h0000_1000, 2'd0);
		send_access(32'h0000_5000, 2'd3);
		for (int t = 6; t <= 9; t++)
			send_access(32'(t) << 12, 2'd0);
		// Sender holds off until every outstanding result has come back.
		drain();
		foreach (addr_pool[i])
			addr_pool[i] = $urandom;
		random_accesses(100);
		for (int g = 0; g < 6; g++) begin
			set_geometry(geo_ob[g], geo_ib[g], geo_nw[g]);
			idle_pct = (g < 2) ? 11 : ((g < 4) ? 65 : 0);
			random_accesses(230);
		end
		drain();
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule
`default_nettype wire
